/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/smalu_pkg.sv */
// ----------------------------------------------------------------------------
// smalu_pkg
// Shared types, constants and helpers for the small matrix ALU.
// ----------------------------------------------------------------------------
package smalu_pkg;

  localparam int DIM         = 3;
  localparam int DATA_W      = 32;
  localparam int CELLS       = DIM * DIM;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int IDX_W       = 2;
  localparam int CMD_W       = 3;
  localparam int VALUE_W     = 32;
  localparam int ELEM_W      = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ELEM_W - 2 * IDX_W;

  // output word field positions
  localparam int OUT_ROW_LSB = ELEM_W;
  localparam int OUT_COL_LSB = ELEM_W + IDX_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_SUB    = 3'd3,
    CMD_MUL    = 3'd4,
    CMD_SCALE  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MULT,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              start;
    logic              ld_prod;
    logic              ld_acc;
    logic              clr_acc;
    logic              ld_out;
    logic              last;
    cmd_t              op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(int'(row) * DIM + int'(col));
  endfunction

endpackage

/* rtl/smalu_ram.sv */
// ----------------------------------------------------------------------------
// smalu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smalu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/smalu_ctrl.sv */
// ----------------------------------------------------------------------------
// smalu_ctrl
// Sequencer: takes commands, walks rows, columns and the inner product index.
// ----------------------------------------------------------------------------
module smalu_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [smalu_pkg::CMD_W-1:0] in_command,
  input  logic [smalu_pkg::IDX_W-1:0] in_row,
  input  logic [smalu_pkg::IDX_W-1:0] in_col,
  input  smalu_pkg::dp_stat_t         stat,
  output smalu_pkg::ctl_cmd_t         cmd
);

  localparam logic [smalu_pkg::IDX_W-1:0] IDX_LAST = smalu_pkg::IDX_W'(smalu_pkg::DIM - 1);
  localparam logic [smalu_pkg::IDX_W-1:0] IDX_LIM  = smalu_pkg::IDX_W'(smalu_pkg::DIM);

  smalu_pkg::state_t              state_r, state_nxt;
  smalu_pkg::cmd_t                op_r, op_nxt;
  logic [smalu_pkg::IDX_W-1:0]    row_r, row_nxt;
  logic [smalu_pkg::IDX_W-1:0]    col_r, col_nxt;
  logic [smalu_pkg::IDX_W-1:0]    k_r, k_nxt;

  smalu_pkg::cmd_t in_cmd;
  logic            accept;
  logic            is_compute;
  logic            in_range;
  logic            more_k;
  logic            last_cell;

  assign in_cmd     = smalu_pkg::cmd_t'(in_command);
  assign in_tready  = (state_r == smalu_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign is_compute = (in_cmd == smalu_pkg::CMD_ADD) || (in_cmd == smalu_pkg::CMD_SUB) ||
                      (in_cmd == smalu_pkg::CMD_MUL) || (in_cmd == smalu_pkg::CMD_SCALE);
  assign in_range   = (in_row < IDX_LIM) && (in_col < IDX_LIM);
  assign more_k     = (op_r == smalu_pkg::CMD_MUL) && (k_r != IDX_LAST);
  assign last_cell  = (row_r == IDX_LAST) && (col_r == IDX_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smalu_pkg::ST_IDLE;
      op_r    <= smalu_pkg::CMD_ADD;
      row_r   <= '0;
      col_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      k_r     <= k_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smalu_pkg::ST_IDLE: begin
        if (accept && is_compute) state_nxt = smalu_pkg::ST_READ;
      end
      smalu_pkg::ST_READ: state_nxt = smalu_pkg::ST_MULT;
      smalu_pkg::ST_MULT: state_nxt = smalu_pkg::ST_ACC;
      smalu_pkg::ST_ACC: begin
        state_nxt = more_k ? smalu_pkg::ST_READ : smalu_pkg::ST_EMIT;
      end
      smalu_pkg::ST_EMIT: begin
        if (stat.out_free) state_nxt = last_cell ? smalu_pkg::ST_IDLE : smalu_pkg::ST_READ;
      end
      default: state_nxt = smalu_pkg::ST_IDLE;
    endcase
  end

  // counters and latched opcode
  always_comb begin
    op_nxt  = op_r;
    row_nxt = row_r;
    col_nxt = col_r;
    k_nxt   = k_r;
    case (state_r)
      smalu_pkg::ST_IDLE: begin
        if (accept && is_compute) begin
          op_nxt  = in_cmd;
          row_nxt = '0;
          col_nxt = '0;
          k_nxt   = '0;
        end
      end
      smalu_pkg::ST_ACC: begin
        if (more_k) k_nxt = k_r + 1'b1;
      end
      smalu_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          k_nxt = '0;
          if (col_r == IDX_LAST) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.op      = op_r;
    cmd.row     = row_r;
    cmd.col     = col_r;
    cmd.last    = last_cell;
    cmd.clr_acc = (k_r == '0);
    cmd.a_addr  = smalu_pkg::cell_addr(row_r, col_r);
    cmd.b_addr  = smalu_pkg::cell_addr(row_r, col_r);
    if (op_r == smalu_pkg::CMD_MUL) begin
      cmd.a_addr = smalu_pkg::cell_addr(row_r, k_r);
      cmd.b_addr = smalu_pkg::cell_addr(k_r, col_r);
    end
    case (state_r)
      smalu_pkg::ST_IDLE: begin
        cmd.wr_a  = accept && in_range && (in_cmd == smalu_pkg::CMD_LOAD_A);
        cmd.wr_b  = accept && in_range && (in_cmd == smalu_pkg::CMD_LOAD_B);
        cmd.start = accept && is_compute;
      end
      smalu_pkg::ST_MULT: cmd.ld_prod = 1'b1;
      smalu_pkg::ST_ACC:  cmd.ld_acc  = 1'b1;
      smalu_pkg::ST_EMIT: cmd.ld_out  = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/smalu_dp.sv */
// ----------------------------------------------------------------------------
// smalu_dp
// Operand stores, shared multiplier/adder, accumulator and output register.
// ----------------------------------------------------------------------------
module smalu_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  smalu_pkg::ctl_cmd_t               cmd,
  output smalu_pkg::dp_stat_t               stat,
  input  logic [smalu_pkg::VALUE_W-1:0]     in_value,
  input  logic [smalu_pkg::IDX_W-1:0]       in_row,
  input  logic [smalu_pkg::IDX_W-1:0]       in_col,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [smalu_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast
);

  logic [smalu_pkg::ADDR_W-1:0] wr_addr;
  logic [smalu_pkg::DATA_W-1:0] wr_data;
  logic [smalu_pkg::DATA_W-1:0] a_data, b_data;

  logic [smalu_pkg::DATA_W-1:0] scalar_r;
  logic [smalu_pkg::DATA_W-1:0] prod_r, prod_nxt;
  logic [smalu_pkg::DATA_W-1:0] acc_r, acc_nxt;

  logic                         out_valid_r;
  logic [smalu_pkg::ELEM_W-1:0] out_elem_r;
  logic [smalu_pkg::IDX_W-1:0]  out_row_r, out_col_r;
  logic                         out_last_r;

  assign wr_addr = smalu_pkg::cell_addr(in_row, in_col);
  assign wr_data = smalu_pkg::DATA_W'(in_value);

  smalu_ram #(.WIDTH(smalu_pkg::DATA_W), .DEPTH(smalu_pkg::CELLS)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (cmd.a_addr),
    .rdata (a_data)
  );

  smalu_ram #(.WIDTH(smalu_pkg::DATA_W), .DEPTH(smalu_pkg::CELLS)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (cmd.b_addr),
    .rdata (b_data)
  );

  // one operation per read pair; products keep the low bits only
  always_comb begin
    case (cmd.op)
      smalu_pkg::CMD_ADD: prod_nxt = a_data + b_data;
      smalu_pkg::CMD_SUB: prod_nxt = a_data - b_data;
      smalu_pkg::CMD_MUL: prod_nxt = a_data * b_data;
      default:            prod_nxt = a_data * scalar_r;
    endcase
  end

  assign acc_nxt = (cmd.clr_acc ? '0 : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    if (cmd.start)   scalar_r <= wr_data;
    if (cmd.ld_prod) prod_r   <= prod_nxt;
    if (cmd.ld_acc)  acc_r    <= acc_nxt;
    if (cmd.ld_out) begin
      out_elem_r <= smalu_pkg::ELEM_W'(acc_r);
      out_row_r  <= cmd.row;
      out_col_r  <= cmd.col;
      out_last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{smalu_pkg::OUT_PAD_W{1'b0}}, out_col_r, out_row_r, out_elem_r};

endmodule

/* rtl/small_matrix_alu.sv */
// ----------------------------------------------------------------------------
// small_matrix_alu
// 3x3 signed matrix unit: element loads, add, subtract, multiply, scale.
//
//   channel  dir  word layout (lsb first)
//   in_      in   command[2:0] row[4:3] col[6:5] value[38:7]
//   out_     out  element[31:0] out_row[33:32] out_col[35:34], tlast = last
//
// A load is written as it is accepted. Add, subtract and scale pass each result
// word through read, operate, accumulate and emit. Multiply runs its 3-term
// dot product through one shared multiplier, repeating read, operate and
// accumulate per term before the emit. Output stalls hold the emit step;
// the output register lets the next command in while the final word waits.
// Reset (rst_n low, synchronous) returns to idle and drops out_tvalid;
// operand contents are undefined until loaded.
// ----------------------------------------------------------------------------
module small_matrix_alu (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command[2:0], row[4:3], col[6:5], value[38:7]
  input  logic [smalu_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // element[31:0], out_row[33:32], out_col[35:34]
  output logic [smalu_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast
);

  smalu_pkg::ctl_cmd_t cmd;
  smalu_pkg::dp_stat_t stat;

  logic [smalu_pkg::CMD_W-1:0]   in_command;
  logic [smalu_pkg::IDX_W-1:0]   in_row, in_col;
  logic [smalu_pkg::VALUE_W-1:0] in_value;

  assign in_command = in_tdata[2:0];
  assign in_row     = in_tdata[4:3];
  assign in_col     = in_tdata[6:5];
  assign in_value   = in_tdata[38:7];

  smalu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_command),
    .in_row     (in_row),
    .in_col     (in_col),
    .stat       (stat),
    .cmd        (cmd)
  );

  smalu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_value   (in_value),
    .in_row     (in_row),
    .in_col     (in_col),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/smalu_checker.sv */
// ----------------------------------------------------------------------------
// smalu_checker
// Port-level checks on the result stream of the small matrix ALU.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smalu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [smalu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tlast
);

  localparam logic [smalu_pkg::IDX_W-1:0] IDX_LAST = smalu_pkg::IDX_W'(smalu_pkg::DIM - 1);

  logic [smalu_pkg::IDX_W-1:0] row, col;
  logic                        corner;

  assign row    = out_tdata[smalu_pkg::OUT_ROW_LSB +: smalu_pkg::IDX_W];
  assign col    = out_tdata[smalu_pkg::OUT_COL_LSB +: smalu_pkg::IDX_W];
  assign corner = (row == IDX_LAST) && (col == IDX_LAST);

  // stalled word holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output word changed")

  // tlast marks exactly the bottom-right element
  `ASSERT_SAME(a_last_corner, clk, rst_n, out_tvalid, out_tlast == corner,
    "tlast does not match final element position")

  // a command is never taken mid-matrix
  `ASSERT_SAME(a_busy_mid, clk, rst_n, out_tvalid && !out_tlast, !in_tready,
    "input ready while result matrix incomplete")

  // a word right after a non-final one differs from it in column or row
  `ASSERT_NEXT(a_order, clk, rst_n, out_tvalid && out_tready && !out_tlast,
    !out_tvalid || (col != $past(col)) || (row != $past(row)),
    "result word repeated")

endmodule

bind small_matrix_alu smalu_checker u_smalu_checker (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for small_matrix_alu. A short table of element loads and matrix
// commands comes first: operand extremes, ignored loads, unused commands.
// Uniform results are typed in, the rest are worked out by an in-bench
// matrix model. Then a random mix of loads and commands with random idle
// input cycles and output back-pressure, both off during a steady stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [smalu_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [smalu_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int RAND_ITEMS = 344;
  localparam logic [31:0] MAX_S = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_S = 32'h8000_0000;

  typedef struct {
    logic [smalu_pkg::CMD_W-1:0] cmd;
    logic [1:0]                  row;
    logic [1:0]                  col;
    logic [31:0]                 value;
    bit                          typed;  // all nine words equal elem
    logic [31:0]                 elem;
  } dir_row_t;

  typedef struct {
    logic [31:0] elem;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        last;
  } elem_word_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [smalu_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [smalu_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              out_tlast;

  logic [31:0] mat_a [smalu_pkg::CELLS];
  logic [31:0] mat_b [smalu_pkg::CELLS];
  elem_word_t  due_elems [$];
  int          mismatches = 0;
  bit          steady = 1'b0;

  // A = all max, B = all min: every matrix operation gives nine equal words
  dir_row_t dir_tab [] = '{
    '{smalu_pkg::CMD_LOAD_A, 2'd0, 2'd0, MAX_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_A, 2'd0, 2'd1, MAX_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_A, 2'd0, 2'd2, MAX_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_A, 2'd1, 2'd0, MAX_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_A, 2'd1, 2'd1, MAX_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_A, 2'd1, 2'd2, MAX_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_A, 2'd2, 2'd0, MAX_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_A, 2'd2, 2'd1, MAX_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_A, 2'd2, 2'd2, MAX_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_B, 2'd0, 2'd0, MIN_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_B, 2'd0, 2'd1, MIN_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_B, 2'd0, 2'd2, MIN_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_B, 2'd1, 2'd0, MIN_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_B, 2'd1, 2'd1, MIN_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_B, 2'd1, 2'd2, MIN_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_B, 2'd2, 2'd0, MIN_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_B, 2'd2, 2'd1, MIN_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_B, 2'd2, 2'd2, MIN_S, 1'b0, 32'h0},
    '{smalu_pkg::CMD_ADD,    2'd0, 2'd0, 32'h0, 1'b1, 32'hFFFF_FFFF},
    '{smalu_pkg::CMD_SUB,    2'd3, 2'd3, 32'h0, 1'b1, 32'hFFFF_FFFF},
    '{smalu_pkg::CMD_MUL,    2'd1, 2'd2, 32'h0, 1'b1, 32'h8000_0000},
    '{smalu_pkg::CMD_SCALE,  2'd0, 2'd0, 32'hFFFF_FFFF, 1'b1, 32'h8000_0001},
    // loads off the matrix must not alias onto real cells
    '{smalu_pkg::CMD_LOAD_A, 2'd3, 2'd0, 32'h0, 1'b0, 32'h0},
    '{smalu_pkg::CMD_LOAD_B, 2'd1, 2'd3, 32'h0, 1'b0, 32'h0},
    '{CMD_SPARE_6, 2'd0, 2'd0, 32'h0, 1'b0, 32'h0},
    '{CMD_SPARE_7, 2'd2, 2'd2, 32'h0, 1'b0, 32'h0},
    '{smalu_pkg::CMD_ADD,    2'd2, 2'd1, 32'h0, 1'b1, 32'hFFFF_FFFF}
  };

  small_matrix_alu dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Updates the operand copies and queues the words a command produces.
  function automatic void apply_command(input logic [smalu_pkg::CMD_W-1:0] cmd,
                                        input logic [1:0] row,
                                        input logic [1:0] col,
                                        input logic [31:0] value);
    elem_word_t  w;
    logic [31:0] acc;
    int          n;
    n = 0;
    case (cmd)
      smalu_pkg::CMD_LOAD_A, smalu_pkg::CMD_LOAD_B: begin
        if (row < smalu_pkg::DIM && col < smalu_pkg::DIM) begin
          if (cmd == smalu_pkg::CMD_LOAD_A) begin
            mat_a[row * smalu_pkg::DIM + col] = value;
          end else begin
            mat_b[row * smalu_pkg::DIM + col] = value;
          end
        end
      end
      smalu_pkg::CMD_ADD, smalu_pkg::CMD_SUB, smalu_pkg::CMD_MUL,
      smalu_pkg::CMD_SCALE: begin
        for (int r = 0; r < smalu_pkg::DIM; r++) begin
          for (int c = 0; c < smalu_pkg::DIM; c++) begin
            case (cmd)
              smalu_pkg::CMD_ADD: begin
                acc = mat_a[r * smalu_pkg::DIM + c] + mat_b[r * smalu_pkg::DIM + c];
              end
              smalu_pkg::CMD_SUB: begin
                acc = mat_a[r * smalu_pkg::DIM + c] - mat_b[r * smalu_pkg::DIM + c];
              end
              smalu_pkg::CMD_MUL: begin
                acc = '0;
                for (int k = 0; k < smalu_pkg::DIM; k++) begin
                  acc = acc + mat_a[r * smalu_pkg::DIM + k] * mat_b[k * smalu_pkg::DIM + c];
                end
              end
              default: acc = mat_a[r * smalu_pkg::DIM + c] * value;
            endcase
            w.elem = acc;
            w.row  = 2'(r);
            w.col  = 2'(c);
            w.last = (n == smalu_pkg::CELLS - 1);
            due_elems.push_back(w);
            n++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return MIN_S;
      1:       return MAX_S;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [smalu_pkg::CMD_W-1:0] cmd, input logic [1:0] row,
                           input logic [1:0] col, input logic [31:0] value);
    while (!steady && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, value, col, row, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic void check_field(input string name, input logic [31:0] got,
                                      input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin : check_out
    elem_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_elems.size() == 0) begin
        $display("%0t: word with none expected, expected nothing, got %h last=%b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = due_elems.pop_front();
        check_field("element", out_tdata[smalu_pkg::ELEM_W-1:0], want.elem);
        check_field("out_row", 32'(out_tdata[smalu_pkg::OUT_ROW_LSB +: smalu_pkg::IDX_W]),
                    32'(want.row));
        check_field("out_col", 32'(out_tdata[smalu_pkg::OUT_COL_LSB +: smalu_pkg::IDX_W]),
                    32'(want.col));
        check_field("last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    logic [smalu_pkg::CMD_W-1:0] cmd;
    logic [1:0]                  row;
    logic [1:0]                  col;
    int                          sel;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].col, dir_tab[i].value);
      if (dir_tab[i].typed) begin
        for (int n = 0; n < smalu_pkg::CELLS; n++) begin
          due_elems.push_back('{dir_tab[i].elem, 2'(n / smalu_pkg::DIM),
                                2'(n % smalu_pkg::DIM), n == smalu_pkg::CELLS - 1});
        end
      end else begin
        apply_command(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].col,
                      dir_tab[i].value);
      end
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      steady = (i >= 100 && i < 180);
      row = 2'($urandom_range(3));
      col = 2'($urandom_range(3));
      sel = $urandom_range(99);
      if (sel < 60) begin
        cmd = $urandom_range(1) ? smalu_pkg::CMD_LOAD_B : smalu_pkg::CMD_LOAD_A;
        row = 2'($urandom_range(2));
        col = 2'($urandom_range(2));
        if ($urandom_range(99) < 8) begin
          if ($urandom_range(1)) row = 2'd3;
          else col = 2'd3;
        end
      end else if (sel < 92) begin
        case ($urandom_range(3))
          0:       cmd = smalu_pkg::CMD_ADD;
          1:       cmd = smalu_pkg::CMD_SUB;
          2:       cmd = smalu_pkg::CMD_MUL;
          default: cmd = smalu_pkg::CMD_SCALE;
        endcase
      end else begin
        cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
      end
      send_word(cmd, row, col, pick_value());
      apply_command(cmd, row, col, in_tdata[38:7]);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (due_elems.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
